@@ design/mdcal_pkg.sv @@
// shared types, command codes and calendar tables for the month/day calendar block
// no dependencies; used by the top level and the bench
package mdcal_pkg;

  // command codes
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_SET_MON = 3'd1;
  localparam logic [2:0] CMD_SET_DAY = 3'd2;
  localparam logic [2:0] CMD_ADD     = 3'd3;
  localparam logic [2:0] CMD_CMP     = 3'd4;

  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned MONTHS       = 12;
  localparam int unsigned REDUCE_STEPS = 7;    // 365 * 2^7 exceeds any biased position
  localparam int unsigned WRAP_YEARS   = 90;   // lifts the most negative position above 0

  localparam logic [15:0] YEAR_DAYS_W  = 16'(YEAR_DAYS);
  localparam logic [3:0]  LAST_MONTH   = 4'(MONTHS);
  localparam logic [2:0]  REDUCE_FIRST = 3'(REDUCE_STEPS - 1);
  localparam logic signed [17:0] WRAP_BIAS = 18'(YEAR_DAYS * WRAP_YEARS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_REDUCE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // length of month m, zero for a month outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] sum;
    case (m)
      4'd2:    sum = 9'd31;
      4'd3:    sum = 9'd59;
      4'd4:    sum = 9'd90;
      4'd5:    sum = 9'd120;
      4'd6:    sum = 9'd151;
      4'd7:    sum = 9'd181;
      4'd8:    sum = 9'd212;
      4'd9:    sum = 9'd243;
      4'd10:   sum = 9'd273;
      4'd11:   sum = 9'd304;
      4'd12:   sum = 9'd334;
      default: sum = 9'd0;
    endcase
    return sum;
  endfunction

  function automatic logic valid_date(input logic [3:0] m, input logic [4:0] d);
    logic [4:0] len;
    len = month_len(m);
    return (len != 5'd0) && (d != 5'd0) && (d <= len);
  endfunction

endpackage

@@ design/month_day_calendar_arith_top.sv @@
// month/day calendar block for a 365-day year: holds one date, runs commands on it
// depends on mdcal_pkg
//
// usage
//   request channel: in_valid/in_ready with command, month_in, day_in, offset.
//   result channel:  out_valid/out_ready with month_out, day_out, day_of_year,
//   error, is_less, is_equal. every request gives exactly one result.
//   load, set month, set day, compare and unused codes go straight from accept
//   to the finish step, which fills the output register. add offset first forms
//   the biased day position in a prep step, then 7 compare-subtract steps reduce
//   it modulo 365, and up to 12 steps walk the month table, all on one shared
//   17-bit subtractor. in_ready is high only while the sequencer is idle, so one
//   request is in flight at a time; a new request is taken only after the last
//   one has left the finish step.
//   the result sits in an output register, so a new request is taken while a
//   finished result waits; a stalled receiver holds the sequencer in its last
//   step until the output register frees.
//   reset (rst, synchronous) sets the date to January 1, empties the output
//   register and returns the sequencer to idle.
module month_day_calendar_arith_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [15:0] offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [8:0]         day_of_year,
  output logic               error,
  output logic               is_less,
  output logic               is_equal
);

  mdcal_pkg::state_t state, state_next;

  // held date
  logic [3:0] cur_month;
  logic [4:0] cur_day;

  // captured request
  logic [2:0]         cmd_q;
  logic [3:0]         month_q;
  logic [4:0]         day_q;
  logic signed [15:0] offset_q;

  // iteration registers: running remainder, reduce step, walk month
  logic [15:0] acc;
  logic [2:0]  step;
  logic [3:0]  walk_month;

  // shared compare-subtract unit
  logic [15:0] sub_operand;
  logic [16:0] sub_diff;
  logic        sub_ge;

  // biased start position for add offset
  logic [8:0]         cur_ordinal;
  logic signed [17:0] position;
  logic [15:0]        position_biased;

  logic in_take;
  logic fin_take;

  // finish step results
  logic [3:0] res_month;
  logic [4:0] res_day;
  logic       res_error;
  logic       res_less;
  logic       res_equal;

  assign in_ready = (state == mdcal_pkg::ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign fin_take = (state == mdcal_pkg::ST_FINISH) && (!out_valid || out_ready);

  // operand picks the scaled year in the reduce phase, the month length in the walk
  always_comb begin
    if (state == mdcal_pkg::ST_REDUCE) begin
      sub_operand = mdcal_pkg::YEAR_DAYS_W << step;
    end else begin
      sub_operand = {11'd0, mdcal_pkg::month_len(walk_month)};
    end
    sub_diff = {1'b0, acc} - {1'b0, sub_operand};
    sub_ge   = !sub_diff[16];
  end

  // position = ordinal - 1 + offset, lifted by whole years when negative
  always_comb begin
    cur_ordinal = mdcal_pkg::days_before(cur_month) + {4'd0, cur_day};
    position    = signed'({9'd0, cur_ordinal}) - 18'sd1
                  + {{2{offset_q[15]}}, offset_q};
    if (position[17]) begin
      position_biased = 16'(position + mdcal_pkg::WRAP_BIAS);
    end else begin
      position_biased = 16'(position);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdcal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      mdcal_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = (command == mdcal_pkg::CMD_ADD) ? mdcal_pkg::ST_PREP
                                                       : mdcal_pkg::ST_FINISH;
        end
      end
      mdcal_pkg::ST_PREP: begin
        state_next = mdcal_pkg::ST_REDUCE;
      end
      mdcal_pkg::ST_REDUCE: begin
        if (step == 3'd0) begin
          state_next = mdcal_pkg::ST_WALK;
        end
      end
      mdcal_pkg::ST_WALK: begin
        // stop at December or when the remainder fits in this month
        if ((walk_month == mdcal_pkg::LAST_MONTH) || !sub_ge) begin
          state_next = mdcal_pkg::ST_FINISH;
        end
      end
      mdcal_pkg::ST_FINISH: begin
        if (fin_take) begin
          state_next = mdcal_pkg::ST_IDLE;
        end
      end
      default: state_next = mdcal_pkg::ST_IDLE;
    endcase
  end

  // request capture and iteration datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= command;
      month_q  <= month_in;
      day_q    <= day_in;
      offset_q <= offset;
    end
    case (state)
      mdcal_pkg::ST_PREP: begin
        acc  <= position_biased;
        step <= mdcal_pkg::REDUCE_FIRST;
      end
      mdcal_pkg::ST_REDUCE: begin
        if (sub_ge) begin
          acc <= sub_diff[15:0];
        end
        step       <= step - 3'd1;
        walk_month <= 4'd1;
      end
      mdcal_pkg::ST_WALK: begin
        if ((walk_month != mdcal_pkg::LAST_MONTH) && sub_ge) begin
          acc        <= sub_diff[15:0];
          walk_month <= walk_month + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // command outcome in the finish step
  always_comb begin
    res_month = cur_month;
    res_day   = cur_day;
    res_error = 1'b0;
    res_less  = 1'b0;
    res_equal = 1'b0;
    case (cmd_q)
      mdcal_pkg::CMD_LOAD: begin
        if (mdcal_pkg::valid_date(month_q, day_q)) begin
          res_month = month_q;
          res_day   = day_q;
        end else begin
          res_error = 1'b1;
        end
      end
      mdcal_pkg::CMD_SET_MON: begin
        if (mdcal_pkg::valid_date(month_q, cur_day)) begin
          res_month = month_q;
        end else begin
          res_error = 1'b1;
        end
      end
      mdcal_pkg::CMD_SET_DAY: begin
        if (mdcal_pkg::valid_date(cur_month, day_q)) begin
          res_day = day_q;
        end else begin
          res_error = 1'b1;
        end
      end
      mdcal_pkg::CMD_ADD: begin
        // remainder left after the walk is below 31
        res_month = walk_month;
        res_day   = acc[4:0] + 5'd1;
      end
      mdcal_pkg::CMD_CMP: begin
        // raw fields compared as given, valid or not
        res_less  = (cur_month < month_q) || ((cur_month == month_q) && (cur_day < day_q));
        res_equal = (cur_month == month_q) && (cur_day == day_q);
      end
      default: ;
    endcase
  end

  // held date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_month <= 4'd1;
      cur_day   <= 5'd1;
    end else if (fin_take) begin
      cur_month <= res_month;
      cur_day   <= res_day;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      month_out   <= res_month;
      day_out     <= res_day;
      day_of_year <= mdcal_pkg::days_before(res_month) + {4'd0, res_day};
      error       <= res_error;
      is_less     <= res_less;
      is_equal    <= res_equal;
    end
  end

endmodule

@@ design/mdcal_checker.sv @@
// port-level checks for the month/day calendar block, bound to the top level
// depends on month_day_calendar_arith_top
module mdcal_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         month_out,
  input logic [4:0]         day_out,
  input logic [8:0]         day_of_year,
  input logic               error,
  input logic               is_less,
  input logic               is_equal
);

  // a result that is not taken holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_of_year) && $stable(month_out))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // result date has month 1 to 12, day at least 1 and day of year 1 to 365
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1
                  && day_of_year >= 9'd1 && day_of_year <= 9'd365)
    else $error("result date out of range");

  // flags exclude each other
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(error && (is_less || is_equal)) && !(is_less && is_equal))
    else $error("conflicting result flags");

endmodule

bind month_day_calendar_arith_top mdcal_checker u_mdcal_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .month_out   (month_out),
  .day_out     (day_out),
  .day_of_year (day_of_year),
  .error       (error),
  .is_less     (is_less),
  .is_equal    (is_equal)
);

@@ bench/month_day_calendar_arith_top_tb.sv @@
// self-checking bench for month_day_calendar_arith_top: directed and random requests
// depends on mdcal_pkg and the block's rtl; holds its own calendar predictor
`timescale 1ns / 100ps

module month_day_calendar_arith_top_tb;

  // spare command codes run from just above compare to the top of the field
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;   // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 32;     // longer than the slowest add offset
  localparam int RANDOM_PER_PHASE = 138;

  localparam int CAL_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [3:0] mon;
    logic [4:0] day;
    logic [8:0] doy;
    logic       err;
    logic       lt;
    logic       eq;
  } cal_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = mdcal_pkg::CMD_LOAD;
  logic [3:0]  month_in = 4'd1;
  logic [4:0]  day_in = 5'd1;
  logic signed [15:0] offset = 16'sd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [8:0]  day_of_year;
  logic        error;
  logic        is_less;
  logic        is_equal;

  // predictor copy of the held date
  logic [3:0] cal_mon = 4'd1;
  logic [4:0] cal_day = 5'd1;

  cal_result_t due_dates [$];
  int fail_count = 0;
  int results_checked = 0;
  int cmd_count [8] = '{default: 0};
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  month_day_calendar_arith_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .month_in    (month_in),
    .day_in      (day_in),
    .offset      (offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .month_out   (month_out),
    .day_out     (day_out),
    .day_of_year (day_of_year),
    .error       (error),
    .is_less     (is_less),
    .is_equal    (is_equal)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  // days in month m, zero outside 1..12
  function automatic int days_of(input logic [3:0] m);
    if (m < 4'd1 || m > 4'd12) return 0;
    return CAL_DAYS[m - 1];
  endfunction

  function automatic logic date_ok(input logic [3:0] m, input logic [4:0] d);
    return (days_of(m) != 0) && (d != 5'd0) && (int'(d) <= days_of(m));
  endfunction

  // ordinal day, january 1 is 1
  function automatic logic [8:0] day_number(input logic [3:0] m, input logic [4:0] d);
    int sum;
    sum = d;
    for (int i = 1; i < m && i <= 12; i++) sum += CAL_DAYS[i - 1];
    return 9'(sum);
  endfunction

  // applies one request to the held date and returns the result it should give
  function automatic cal_result_t advance_calendar(input logic [2:0] cmd,
                                                   input logic [3:0] mon,
                                                   input logic [4:0] day,
                                                   input logic [15:0] off);
    cal_result_t r;
    int pos;
    int step_days;
    logic [3:0] mm;
    r.err = 1'b0;
    r.lt  = 1'b0;
    r.eq  = 1'b0;
    case (cmd)
      mdcal_pkg::CMD_LOAD: begin
        if (date_ok(mon, day)) begin
          cal_mon = mon;
          cal_day = day;
        end else r.err = 1'b1;
      end
      mdcal_pkg::CMD_SET_MON: begin
        if (date_ok(mon, cal_day)) cal_mon = mon;
        else r.err = 1'b1;
      end
      mdcal_pkg::CMD_SET_DAY: begin
        if (date_ok(cal_mon, day)) cal_day = day;
        else r.err = 1'b1;
      end
      mdcal_pkg::CMD_ADD: begin
        step_days = $signed(off);
        // signed remainder truncates toward zero, so fold negatives back up
        pos = (int'(day_number(cal_mon, cal_day)) - 1 + step_days) % 365;
        if (pos < 0) pos += 365;
        mm = 4'd1;
        while (mm < 4'd12 && pos >= days_of(mm)) begin
          pos -= days_of(mm);
          mm++;
        end
        cal_mon = mm;
        cal_day = 5'(pos + 1);
      end
      mdcal_pkg::CMD_CMP: begin
        // raw given date, valid or not
        r.lt = (cal_mon < mon) || (cal_mon == mon && cal_day < day);
        r.eq = (cal_mon == mon) && (cal_day == day);
      end
      default: begin
      end
    endcase
    r.mon = cal_mon;
    r.day = cal_day;
    r.doy = day_number(cal_mon, cal_day);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // random idle gap, then hold the request until the block takes it;
  // valid is only lowered when a gap is drawn, so back-to-back requests keep it high
  task automatic send_req(input logic [2:0] cmd, input logic [3:0] mon,
                          input logic [4:0] day, input logic [15:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    month_in <= mon;
    day_in   <= day;
    offset   <= off;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: predict now, one request in flight at a time
    due_dates.push_back(advance_calendar(cmd, mon, day, off));
    cmd_count[cmd]++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    cal_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_dates.size() == 0) begin
        $error("result with no pending request: month_out %0d, day_out %0d",
               month_out, day_out);
        fail_count++;
      end else begin
        want = due_dates.pop_front();
        check_field("month_out", want.mon, month_out);
        check_field("day_out", want.day, day_out);
        check_field("day_of_year", want.doy, day_of_year);
        check_field("error", want.err, error);
        check_field("is_less", want.lt, is_less);
        check_field("is_equal", want.eq, is_equal);
        results_checked++;
      end
    end
  end

  // any handshake on either side keeps the run alive
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, due_dates.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // year ends, end of february, and invalid dates that must leave the state alone
  task automatic test_load_dates();
    send_req(mdcal_pkg::CMD_LOAD, 4'd12, 5'd31, 16'h0000);
    send_req(mdcal_pkg::CMD_LOAD, 4'd2, 5'd28, 16'hFFFF);
    send_req(mdcal_pkg::CMD_LOAD, 4'd2, 5'd29, 16'h0000);
    send_req(mdcal_pkg::CMD_LOAD, 4'd0, 5'd0, 16'h0000);
    send_req(mdcal_pkg::CMD_LOAD, 4'd15, 5'd31, 16'h7FFF);
    send_req(mdcal_pkg::CMD_LOAD, 4'd4, 5'd31, 16'h8000);
  endtask

  // set month checks against the held day, set day against the held month
  task automatic test_set_fields();
    send_req(mdcal_pkg::CMD_LOAD, 4'd4, 5'd30, 16'h0000);
    send_req(mdcal_pkg::CMD_SET_DAY, 4'd0, 5'd31, 16'h0000);
    send_req(mdcal_pkg::CMD_SET_MON, 4'd15, 5'd0, 16'h0000);
    send_req(mdcal_pkg::CMD_SET_MON, 4'd12, 5'd31, 16'h0000);
    send_req(mdcal_pkg::CMD_SET_DAY, 4'd15, 5'd0, 16'h0000);
    send_req(mdcal_pkg::CMD_SET_MON, 4'd2, 5'd1, 16'h0000);
  endtask

  // wrap forward across new year and step back, then offsets at the extremes of the field
  task automatic test_add_offset();
    send_req(mdcal_pkg::CMD_ADD, 4'd0, 5'd0, 16'd1);
    send_req(mdcal_pkg::CMD_ADD, 4'd15, 5'd31, 16'd1);
    send_req(mdcal_pkg::CMD_ADD, 4'd0, 5'd0, 16'hFFFF);
    send_req(mdcal_pkg::CMD_ADD, 4'd0, 5'd0, 16'h7FFF);
    send_req(mdcal_pkg::CMD_ADD, 4'd0, 5'd0, 16'h8000);
    send_req(mdcal_pkg::CMD_ADD, 4'd0, 5'd0, 16'd365);
  endtask

  // equal, later month, earlier day, and an out-of-range given date
  task automatic test_compare();
    send_req(mdcal_pkg::CMD_LOAD, 4'd6, 5'd15, 16'h0000);
    send_req(mdcal_pkg::CMD_CMP, 4'd6, 5'd15, 16'h0000);
    send_req(mdcal_pkg::CMD_CMP, 4'd7, 5'd1, 16'h0000);
    send_req(mdcal_pkg::CMD_CMP, 4'd6, 5'd14, 16'h0000);
    send_req(mdcal_pkg::CMD_CMP, 4'd15, 5'd31, 16'hFFFF);
  endtask

  // spare codes: date held, all flags low
  task automatic test_spare_commands();
    for (int c = mdcal_pkg::CMD_CMP + 1; c <= CMD_SPARE_LAST; c++)
      send_req(3'(c), 4'($urandom), 5'($urandom), 16'($urandom));
  endtask

  // mostly meaningful requests around the held date, with raw noise mixed in
  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n);
    int sel;
    logic [2:0]  cmd;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [15:0] off;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      mon = 4'($urandom);
      day = 5'($urandom);
      off = 16'($urandom);
      if (sel < 20) begin
        cmd = mdcal_pkg::CMD_LOAD;
        mon = 4'($urandom_range(1, 12));
        day = 5'($urandom_range(1, days_of(mon)));
      end else if (sel < 26) begin
        cmd = mdcal_pkg::CMD_LOAD;
      end else if (sel < 36) begin
        cmd = mdcal_pkg::CMD_SET_MON;
        if ($urandom_range(3) != 0) mon = 4'($urandom_range(1, 12));
      end else if (sel < 46) begin
        cmd = mdcal_pkg::CMD_SET_DAY;
        if ($urandom_range(3) != 0) day = 5'($urandom_range(1, 31));
      end else if (sel < 74) begin
        cmd = mdcal_pkg::CMD_ADD;
        // small steps stay near month borders, full-width ones exercise the reduction
        if ($urandom_range(1) != 0) off = 16'(int'($urandom_range(0, 800)) - 400);
      end else if (sel < 95) begin
        cmd = mdcal_pkg::CMD_CMP;
        if ($urandom_range(3) != 0) begin
          mon = 4'(int'(cal_mon) + int'($urandom_range(2)) - 1);
          day = 5'(int'(cal_day) + int'($urandom_range(2)) - 1);
        end
      end else begin
        cmd = 3'($urandom_range(mdcal_pkg::CMD_CMP + 1, CMD_SPARE_LAST));
      end
      send_req(cmd, mon, day, off);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part without idling
    test_load_dates();
    test_set_fields();
    test_add_offset();
    test_compare();
    test_spare_commands();

    // random part across the four pressure phases
    test_random_mix(0, 0, RANDOM_PER_PHASE);
    test_random_mix(57, 0, RANDOM_PER_PHASE);
    test_random_mix(0, 57, RANDOM_PER_PHASE);
    test_random_mix(15, 15, RANDOM_PER_PHASE);

    @(posedge clk);
    in_valid <= 1'b0;
    while (due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_dates.size() != 0) begin
      $error("%0d results never arrived", due_dates.size());
      fail_count++;
    end

    $display("run covered %0d requests: load %0d, set month %0d, set day %0d, add %0d,",
             cmd_count.sum(), cmd_count[mdcal_pkg::CMD_LOAD],
             cmd_count[mdcal_pkg::CMD_SET_MON], cmd_count[mdcal_pkg::CMD_SET_DAY],
             cmd_count[mdcal_pkg::CMD_ADD]);
    $display("compare %0d, spare codes %0d; %0d results checked under four stall mixes",
             cmd_count[mdcal_pkg::CMD_CMP],
             cmd_count[5] + cmd_count[6] + cmd_count[CMD_SPARE_LAST],
             results_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
